// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/flwg_pkg.sv -----
package flwg_pkg;

    // Phase is an unsigned fraction of a turn.
    localparam int PHASE_BITS       = 16;
    localparam int QUARTER_W        = PHASE_BITS - 2;
    localparam int STEP_SHIFT       = 42 - PHASE_BITS;

    // Quarter-wave sine table, entries 0 to SINE_TABLE_DEPTH inclusive.
    localparam int SINE_TABLE_DEPTH = 256;
    localparam int SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int SINE_W           = 17;

    localparam int SQ_W             = 32;
    localparam int ROOT_W           = 16;
    localparam int SPEED_W          = 17;

    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 8;

    // Fixed-point constants.
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam int STEP_K           = 62582;
    localparam int SPEED_RECIP      = 2684355;   // ceil(2^26 / 25), speed = m * 64 / 25
    localparam int SPEED_SHIFT      = 20;
    localparam int SPEED_MAX        = 65536;
    localparam int NEUTRAL_SCALE    = 25;        // 3276800 = 25 * 2^17
    localparam int ANGLE_DIV_SHIFT  = 17;
    localparam int ANGLE_RECIP      = 10486;     // ceil(2^18 / 25)
    localparam int ANGLE_SHIFT      = 18;
    localparam int ANGLE_X_MAX      = 4525;      // 181 * 25
    localparam int ANGLE_MAX        = 180;
    localparam int TILT_RECIP       = 410;       // ceil(2^12 / 10)
    localparam int TILT_SHIFT       = 12;

    localparam logic [6:0] DEAD_ZONE_RST     = 7'd5;
    localparam logic [7:0] FRONT_NEUTRAL_RST = 8'd110;
    localparam logic [7:0] HIND_NEUTRAL_RST  = 8'd90;
    localparam logic [6:0] SWING_LIMIT_RST   = 7'd35;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEAD_ZONE     = 2'd0,
        CFG_FRONT_NEUTRAL = 2'd1,
        CFG_HIND_NEUTRAL  = 2'd2,
        CFG_SWING_LIMIT   = 2'd3
    } cfg_idx_t;

    typedef logic signed [7:0]       stick_t;
    typedef logic [9:0]              dtime_t;
    typedef logic [7:0]              angle_t;
    typedef logic [PHASE_BITS-1:0]   phase_t;
    typedef logic [15:0]             sine_tab_t [SINE_TABLE_DEPTH+1];

    // One table entry: Taylor series of sin in Q30, rounded to Q1.15.
    function automatic logic [15:0] sine_entry(input int unsigned i);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] q;
        x    = (64'(i) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        term = ((term * x2) >> 30) / 6;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 20;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 42;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 72;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 110;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 156;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 210;
        sum  = sum - term;
        if (sum[63])
        begin
            sum = '0;
        end
        q = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
        if (q > 64'd32767)
        begin
            q = 64'd32767;
        end
        return q[15:0];
    endfunction

    function automatic sine_tab_t build_sine_tab();
        sine_tab_t tab;
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++)
        begin
            tab[i] = sine_entry(i);
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

// ----- hw/rtl/flwg_if.sv -----
interface flwg_in_if;
    import flwg_pkg::*;

    logic   valid;
    logic   ready;
    stick_t throttle;
    stick_t yaw;
    stick_t pitch;
    stick_t roll;
    dtime_t elapsed_time;

    modport source (
        output valid, throttle, yaw, pitch, roll, elapsed_time,
        input  ready
    );
    modport sink (
        input  valid, throttle, yaw, pitch, roll, elapsed_time,
        output ready
    );
endinterface

interface flwg_out_if;
    import flwg_pkg::*;

    logic   valid;
    logic   ready;
    angle_t front_left_angle;
    angle_t front_right_angle;
    angle_t hind_left_angle;
    angle_t hind_right_angle;

    modport source (
        output valid, front_left_angle, front_right_angle, hind_left_angle,
               hind_right_angle,
        input  ready
    );
    modport sink (
        input  valid, front_left_angle, front_right_angle, hind_left_angle,
               hind_right_angle,
        output ready
    );
endinterface

// ----- hw/rtl/four_leg_walk_gait_generator_unit.sv -----
// A standing item (both sticks inside the dead zone) passes through the still and done states
// only; a walking item runs the square root (16 iterations, then a done flag), the speed and
// step states, and per leg the sine, amplitude, swing, numerator, divide and angle states.
// One item at a time: a new item is accepted only in idle, entered once the previous result
// enters the output register, which waits while a held result has not been taken.
// Reset (rst_n, asynchronous, active low) clears the gait phase and loads register defaults.
`include "assert_macros.svh"

module four_leg_walk_gait_generator_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    flwg_in_if.sink                         tick,
    flwg_out_if.source                      servo,
    input  logic                            cfg_we,
    input  logic [flwg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [flwg_pkg::CFG_DATA_W-1:0] cfg_data
);
    import flwg_pkg::*;

    typedef enum logic [17:0] {
        ST_IDLE       = 18'h00001,
        ST_STILL      = 18'h00002,
        ST_SQ_T       = 18'h00004,
        ST_SQ_Y       = 18'h00008,
        ST_ROOT_GO    = 18'h00010,
        ST_ROOT_WAIT  = 18'h00020,
        ST_SPEED_MUL  = 18'h00040,
        ST_SPEED_SAT  = 18'h00080,
        ST_STEP_DT    = 18'h00100,
        ST_STEP_K     = 18'h00200,
        ST_PHASE      = 18'h00400,
        ST_LEG_SINE   = 18'h00800,
        ST_LEG_AMP    = 18'h01000,
        ST_LEG_SWING  = 18'h02000,
        ST_LEG_NUM    = 18'h04000,
        ST_LEG_DIV    = 18'h08000,
        ST_LEG_ANGLE  = 18'h10000,
        ST_DONE       = 18'h20000
    } state_t;

    localparam int MUL_A_W = 28;
    localparam int MUL_B_W = 24;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int IDX_PROD_W = QUARTER_W + SINE_IDX_W;

    // Phase offset of each leg in quarter turns: FL, FR, HL, HR.
    localparam logic [1:0] LEG_QUARTER [4] = '{2'd0, 2'd2, 2'd3, 2'd1};

    state_t state_reg, state_next;

    // Configuration.
    logic [6:0] dz_reg;
    logic [7:0] fn_reg;
    logic [7:0] hn_reg;
    logic [6:0] swing_reg;

    // Latched item.
    stick_t t_reg;
    stick_t y_reg;
    stick_t pitch_reg;
    stick_t roll_reg;
    dtime_t dt_reg;

    phase_t phase_reg, phase_next;
    logic [1:0] leg_reg, leg_next;

    logic        [15:0]        sq_t_reg, sq_t_next;
    logic signed [PROD_W-1:0]  prod_reg;
    logic        [SPEED_W-1:0] speed_reg, speed_next;
    logic signed [SINE_W-1:0]  sine_reg, sine_next;
    logic signed [31:0]        num_reg, num_next;
    angle_t                    angle_reg [4];
    angle_t                    angle_next [4];

    logic   out_valid_reg, out_valid_next;
    angle_t out_angle_reg [4];

    // Shared multiplier.
    logic                      mul_en;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;

    // Square root unit.
    logic [SQ_W-1:0]   sqrt_in;
    logic [ROOT_W-1:0] sqrt_root;
    logic              sqrt_done;
    logic [15:0]       sq_sum;

    logic       accept;
    logic [8:0] abs_t;
    logic [8:0] abs_y;
    logic       standing;

    // Per-leg datapath values.
    phase_t                   p_leg;
    logic [1:0]               quad;
    logic [QUARTER_W-1:0]     rest;
    logic [IDX_PROD_W-1:0]    idx_prod;
    logic [SINE_IDX_W-1:0]    idx_base;
    logic [SINE_IDX_W-1:0]    idx;
    logic [15:0]              tab_val;
    logic signed [8:0]        amp;
    logic [7:0]               neutral;
    logic [12:0]              neutral_x25;
    logic [14:0]              num_hi;
    logic [12:0]              div_x;
    logic [8:0]               leg_q;
    logic [PHASE_BITS-1:0]    step_d;
    logic [PROD_W-1-SPEED_SHIFT:0] speed_q;

    // Standing tilt.
    logic signed [6:0]  tilt_p;
    logic signed [6:0]  tilt_r;
    logic signed [10:0] fn_s;
    logic signed [10:0] hn_s;

    // Root check used by an assertion.
    logic [32:0] root_sq;
    logic [32:0] root_sq_up;

    // trunc(3 * v / 10), toward zero.
    function automatic logic signed [6:0] tilt(input logic signed [7:0] v);
        logic signed [9:0] v3;
        logic [8:0]        mag;
        logic [17:0]       scaled;
        logic [6:0]        q;
        v3     = 10'(v) + 10'(v) + 10'(v);
        mag    = v3[9] ? 9'(-v3) : 9'(v3);
        scaled = 18'(mag) * 18'(TILT_RECIP);
        q      = 7'(scaled >> TILT_SHIFT);
        return v3[9] ? -q : q;
    endfunction

    function automatic angle_t sat_angle(input logic signed [10:0] v);
        angle_t a;
        if (v < 0)
        begin
            a = '0;
        end
        else if (v > 11'sd180)
        begin
            a = 8'(ANGLE_MAX);
        end
        else
        begin
            a = v[7:0];
        end
        return a;
    endfunction

    flwg_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == ST_ROOT_GO),
        .radicand (sqrt_in),
        .root     (sqrt_root),
        .done     (sqrt_done)
    );

    assign tick.ready = (state_reg == ST_IDLE);
    assign accept     = tick.valid && tick.ready;

    assign abs_t    = tick.throttle[7] ? 9'(-9'(tick.throttle)) : 9'(tick.throttle);
    assign abs_y    = tick.yaw[7] ? 9'(-9'(tick.yaw)) : 9'(tick.yaw);
    assign standing = (abs_t < {2'b00, dz_reg}) && (abs_y < {2'b00, dz_reg});

    assign sq_sum  = sq_t_reg + prod_reg[15:0];
    assign sqrt_in = {sq_sum, 16'h0000};

    // Sine lookup for the current leg.
    assign p_leg    = phase_reg + (PHASE_BITS'(LEG_QUARTER[leg_reg]) << QUARTER_W);
    assign quad     = p_leg[PHASE_BITS-1 -: 2];
    assign rest     = p_leg[QUARTER_W-1:0];
    assign idx_prod = IDX_PROD_W'(rest) * IDX_PROD_W'(SINE_TABLE_DEPTH);
    assign idx_base = SINE_IDX_W'(idx_prod >> QUARTER_W);
    assign idx      = quad[0] ? SINE_IDX_W'(SINE_TABLE_DEPTH) - idx_base : idx_base;
    assign tab_val  = SINE_TAB[idx];

    // Left legs mix throttle + yaw, right legs throttle - yaw.
    assign amp     = leg_reg[0] ? 9'(t_reg) - 9'(y_reg) : 9'(t_reg) + 9'(y_reg);
    assign neutral = leg_reg[1] ? hn_reg : fn_reg;
    assign neutral_x25 = 13'(neutral) * 13'(NEUTRAL_SCALE);

    assign num_hi = num_reg[31:ANGLE_DIV_SHIFT];
    assign div_x  = num_reg[31] ? 13'd0 :
                    (num_hi >= 15'(ANGLE_X_MAX)) ? 13'(ANGLE_X_MAX) : num_hi[12:0];
    assign leg_q  = prod_reg[ANGLE_SHIFT +: 9];

    assign step_d  = prod_reg[STEP_SHIFT +: PHASE_BITS];
    assign speed_q = prod_reg[PROD_W-1:SPEED_SHIFT];

    assign tilt_p = tilt(pitch_reg);
    assign tilt_r = tilt(roll_reg);
    assign fn_s   = $signed({3'b000, fn_reg});
    assign hn_s   = $signed({3'b000, hn_reg});

    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        unique case (state_reg)
            ST_SQ_T:
            begin
                mul_a = MUL_A_W'(t_reg);
                mul_b = MUL_B_W'(t_reg);
            end
            ST_SQ_Y:
            begin
                mul_a = MUL_A_W'(y_reg);
                mul_b = MUL_B_W'(y_reg);
            end
            ST_SPEED_MUL:
            begin
                mul_a = MUL_A_W'(sqrt_root);
                mul_b = MUL_B_W'(SPEED_RECIP);
            end
            ST_STEP_DT:
            begin
                mul_a = MUL_A_W'(speed_reg);
                mul_b = MUL_B_W'(dt_reg);
            end
            ST_STEP_K:
            begin
                mul_a = MUL_A_W'(prod_reg[26:0]);
                mul_b = MUL_B_W'(STEP_K);
            end
            ST_LEG_AMP:
            begin
                mul_a = MUL_A_W'(sine_reg);
                mul_b = MUL_B_W'(amp);
            end
            ST_LEG_SWING:
            begin
                mul_a = prod_reg[MUL_A_W-1:0];
                mul_b = MUL_B_W'(swing_reg);
            end
            ST_LEG_DIV:
            begin
                mul_a = MUL_A_W'(div_x);
                mul_b = MUL_B_W'(ANGLE_RECIP);
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        leg_next       = leg_reg;
        sq_t_next      = sq_t_reg;
        speed_next     = speed_reg;
        sine_next      = sine_reg;
        num_next       = num_reg;
        angle_next     = angle_reg;
        out_valid_next = out_valid_reg && !servo.ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = standing ? ST_STILL : ST_SQ_T;
                end
            end
            ST_STILL:
            begin
                phase_next    = '0;
                angle_next[0] = sat_angle(fn_s + 11'(tilt_p) + 11'(tilt_r));
                angle_next[1] = sat_angle(fn_s + 11'(tilt_p) - 11'(tilt_r));
                angle_next[2] = sat_angle(hn_s - 11'(tilt_p) + 11'(tilt_r));
                angle_next[3] = sat_angle(hn_s - 11'(tilt_p) - 11'(tilt_r));
                state_next    = ST_DONE;
            end
            ST_SQ_T:
            begin
                state_next = ST_SQ_Y;
            end
            ST_SQ_Y:
            begin
                sq_t_next  = prod_reg[15:0];
                state_next = ST_ROOT_GO;
            end
            ST_ROOT_GO:
            begin
                state_next = ST_ROOT_WAIT;
            end
            ST_ROOT_WAIT:
            begin
                if (sqrt_done)
                begin
                    state_next = ST_SPEED_MUL;
                end
            end
            ST_SPEED_MUL:
            begin
                state_next = ST_SPEED_SAT;
            end
            ST_SPEED_SAT:
            begin
                speed_next = (speed_q > (PROD_W - SPEED_SHIFT)'(SPEED_MAX)) ?
                             SPEED_W'(SPEED_MAX) : speed_q[SPEED_W-1:0];
                state_next = ST_STEP_DT;
            end
            ST_STEP_DT:
            begin
                state_next = ST_STEP_K;
            end
            ST_STEP_K:
            begin
                state_next = ST_PHASE;
            end
            ST_PHASE:
            begin
                // Negative throttle walks the phase backward.
                phase_next = t_reg[7] ? phase_reg - step_d : phase_reg + step_d;
                leg_next   = '0;
                state_next = ST_LEG_SINE;
            end
            ST_LEG_SINE:
            begin
                sine_next  = quad[1] ? -$signed({1'b0, tab_val}) : $signed({1'b0, tab_val});
                state_next = ST_LEG_AMP;
            end
            ST_LEG_AMP:
            begin
                state_next = ST_LEG_SWING;
            end
            ST_LEG_SWING:
            begin
                state_next = ST_LEG_NUM;
            end
            ST_LEG_NUM:
            begin
                num_next   = $signed(32'(neutral_x25) << ANGLE_DIV_SHIFT) + prod_reg[31:0];
                state_next = ST_LEG_DIV;
            end
            ST_LEG_DIV:
            begin
                state_next = ST_LEG_ANGLE;
            end
            ST_LEG_ANGLE:
            begin
                angle_next[leg_reg] = (leg_q > 9'(ANGLE_MAX)) ? 8'(ANGLE_MAX) : leg_q[7:0];
                leg_next            = leg_reg + 2'd1;
                state_next          = (leg_reg == 2'd3) ? ST_DONE : ST_LEG_SINE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || servo.ready)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= '0;
            leg_reg       <= '0;
            out_valid_reg <= 1'b0;
            dz_reg        <= DEAD_ZONE_RST;
            fn_reg        <= FRONT_NEUTRAL_RST;
            hn_reg        <= HIND_NEUTRAL_RST;
            swing_reg     <= SWING_LIMIT_RST;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            leg_reg       <= leg_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_DEAD_ZONE:     dz_reg    <= cfg_data[6:0];
                    CFG_FRONT_NEUTRAL: fn_reg    <= cfg_data;
                    CFG_HIND_NEUTRAL:  hn_reg    <= cfg_data;
                    CFG_SWING_LIMIT:   swing_reg <= cfg_data[6:0];
                    default:           dz_reg    <= dz_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            t_reg     <= tick.throttle;
            y_reg     <= tick.yaw;
            pitch_reg <= tick.pitch;
            roll_reg  <= tick.roll;
            dt_reg    <= tick.elapsed_time;
        end
        if (mul_en)
        begin
            prod_reg <= mul_p;
        end
        sq_t_reg  <= sq_t_next;
        speed_reg <= speed_next;
        sine_reg  <= sine_next;
        num_reg   <= num_next;
        angle_reg <= angle_next;
        if ((state_reg == ST_DONE) && (!out_valid_reg || servo.ready))
        begin
            out_angle_reg <= angle_reg;
        end
    end

    assign servo.valid             = out_valid_reg;
    assign servo.front_left_angle  = out_angle_reg[0];
    assign servo.front_right_angle = out_angle_reg[1];
    assign servo.hind_left_angle   = out_angle_reg[2];
    assign servo.hind_right_angle  = out_angle_reg[3];

    assign root_sq    = 33'(sqrt_root) * 33'(sqrt_root);
    assign root_sq_up = (33'(sqrt_root) + 33'd1) * (33'(sqrt_root) + 33'd1);

    `ASSERT_NEXT(a_out_load, clk, rst_n, (state_reg == ST_DONE) && (!out_valid_reg || servo.ready), servo.valid && tick.ready, "result not handed to output register")
    `ASSERT_IMPLIES(a_angle_range, clk, rst_n, servo.valid, (servo.front_left_angle <= 8'd180) && (servo.front_right_angle <= 8'd180) && (servo.hind_left_angle <= 8'd180) && (servo.hind_right_angle <= 8'd180), "servo angle above 180")
    `ASSERT_NEXT(a_still_phase, clk, rst_n, state_reg == ST_STILL, phase_reg == '0, "phase not cleared when standing")
    `ASSERT_IMPLIES(a_root_exact, clk, rst_n, state_reg == ST_SPEED_MUL, (root_sq <= 33'(sqrt_in)) && (root_sq_up > 33'(sqrt_in)), "square root not exact")

endmodule

// ----- hw/rtl/flwg_isqrt.sv -----
`include "assert_macros.svh"

module flwg_isqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [flwg_pkg::SQ_W-1:0]   radicand,
    output logic [flwg_pkg::ROOT_W-1:0] root,
    output logic                        done
);
    import flwg_pkg::*;

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [SQ_W-1:0] bit_reg, bit_next;
    logic [SQ_W-1:0] rem_reg, rem_next;
    logic [SQ_W-1:0] res_reg, res_next;
    logic [SQ_W:0]   trial;

    // One bit of the root is resolved each cycle, SQ_W / 2 bits in all.
    assign trial = {1'b0, res_reg} + {1'b0, bit_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        bit_next  = bit_reg;
        rem_next  = rem_reg;
        res_next  = res_reg;
        if (start)
        begin
            busy_next = 1'b1;
            bit_next  = SQ_W'(1) << (SQ_W - 2);
            rem_next  = radicand;
            res_next  = '0;
        end
        else if (busy_reg)
        begin
            if ({1'b0, rem_reg} >= trial)
            begin
                rem_next = rem_reg - trial[SQ_W-1:0];
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0])
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            bit_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            bit_reg  <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        res_reg <= res_next;
    end

    assign root = res_reg[ROOT_W-1:0];
    assign done = done_reg;

    `ASSERT_IMPLIES(a_bit_onehot, clk, rst_n, busy_reg, $onehot(bit_reg), "isqrt: bit not one-hot")
    `ASSERT_IMPLIES(a_start_idle, clk, rst_n, start, !busy_reg, "isqrt: start while busy")
    `ASSERT_IMPLIES(a_done_idle, clk, rst_n, done_reg, !busy_reg, "isqrt: done while busy")

endmodule
